// ===== src/rcpwt_pkg.sv =====
// Shared constants, types and helper functions for the pulse-width remote code transmitter.
// No dependencies; imported by remote_code_pulse_width_transmitter.

package rcpwt_pkg;

   // Code word layout: high word, low word, appended zero bit.
   localparam int HIGH_BITS       = 32;
   localparam int LOW_BITS        = 24;
   localparam int TOTAL_BITS      = HIGH_BITS + LOW_BITS;
   localparam int BIT_INDEX_WIDTH = $clog2(TOTAL_BITS);

   // Configuration port.
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register reset values.
   localparam logic [7:0] PREAMBLE_PULSES_RESET  = 8'd48;
   localparam logic [3:0] REPEAT_COUNT_RESET     = 4'd4;
   localparam logic [3:0] START_HIGH_UNITS_RESET = 4'd4;
   localparam logic [7:0] GAP_UNITS_RESET        = 8'd36;

   // Number of units in one code bit symbol is three; the last unit index is two.
   localparam logic [8:0] BIT_LAST_UNIT = 9'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PREAMBLE_PULSES  = 2'd0,
      CSR_REPEAT_COUNT     = 2'd1,
      CSR_START_HIGH_UNITS = 2'd2,
      CSR_GAP_UNITS        = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PHASE_IDLE  = 3'd0,
      PHASE_PRE   = 3'd1,
      PHASE_START = 3'd2,
      PHASE_BITS  = 3'd3,
      PHASE_GAP   = 3'd4
   } phase_type;

   // A count or length of zero behaves as one.
   function automatic logic [7:0] at_least_one(input logic [7:0] value);
      at_least_one = (value == 8'd0) ? 8'd1 : value;
   endfunction

endpackage

// ===== src/remote_code_pulse_width_transmitter.sv =====
// Top level of the pulse-width remote code transmitter: frame sequencer and result register.
// Depends on rcpwt_pkg for constants, the phase type and register indexes.
//
// Usage:
//   The req_ channel carries one beat per protocol time unit (req_mode = 0) or a
//   start request (req_mode = 1) with the code words in req_code_high and
//   req_code_low. A start is taken only while idle; a start while busy is ignored.
//   Every request beat yields exactly one rsp_ beat with the line level for that
//   unit, the busy flag and the done flag for the last unit of the last frame.
//   The response beat is registered and valid in the cycle after the request is
//   accepted. Throughput is one beat per cycle while rsp_ready is high; the
//   sequencer step is a single pass of counter compares between the state registers
//   and the response register. req_ready is high while the response register is empty
//   or being drained in the same cycle, so a stalled receiver holds the response beat
//   and blocks the next request beat only for as long as it stalls.
//   The csr_ port writes one register per cycle with csr_we; the registers are read
//   live, so a write changes the transmission from the next beat on. Reset is
//   synchronous: it returns the sequencer to idle, empties the response register
//   and restores the register defaults
//   (48 preamble pulses, 4 frames, 4 start units, 36 gap units).

module remote_code_pulse_width_transmitter
   import rcpwt_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   input  logic [HIGH_BITS-1:0]       req_code_high,
   input  logic [LOW_BITS-2:0]        req_code_low,
   // Response channel.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_line_level,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   // Configuration write port.
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Configuration registers.
   logic [7:0] preamble_pulses_ff;
   logic [3:0] repeat_count_ff;
   logic [3:0] start_high_units_ff;
   logic [7:0] gap_units_ff;

   // Sequencer state.
   phase_type                  phase_ff, phase_in;
   logic [7:0]                 unit_counter_ff, unit_counter_in;
   logic [7:0]                 pulse_counter_ff, pulse_counter_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic [3:0]                 repeat_counter_ff, repeat_counter_in;
   logic [TOTAL_BITS-1:0]      code_ff, code_in;

   // Response register.
   logic rsp_valid_ff, rsp_valid_in;
   logic line_level_ff, line_level_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   // Helper values for the sequencer step.
   logic                     req_accept;
   logic [8:0]               unit_plus_one;
   logic [8:0]               pulse_plus_one;
   logic [BIT_INDEX_WIDTH:0] bit_index_plus_one;
   logic [4:0]               repeat_plus_one;
   logic [8:0]               unit_wide;
   logic [8:0]               preamble_limit;
   logic [8:0]               start_limit;
   logic [8:0]               gap_limit;
   logic [4:0]               repeat_limit;
   logic                     current_bit;
   logic [8:0]               bit_high_len;

   // Handshake: the response register is free or drains this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign unit_plus_one      = {1'b0, unit_counter_ff} + 9'd1;
   assign pulse_plus_one     = {1'b0, pulse_counter_ff} + 9'd1;
   assign bit_index_plus_one = {1'b0, bit_index_ff} + {{BIT_INDEX_WIDTH{1'b0}}, 1'b1};
   assign repeat_plus_one    = {1'b0, repeat_counter_ff} + 5'd1;
   assign unit_wide          = {1'b0, unit_counter_ff};
   assign preamble_limit     = {1'b0, at_least_one(preamble_pulses_ff)};
   assign start_limit        = {1'b0, at_least_one({4'd0, start_high_units_ff})};
   assign gap_limit          = {1'b0, at_least_one(gap_units_ff)};
   assign repeat_limit       = 5'(at_least_one({4'd0, repeat_count_ff}));

   // The code register rotates left once per finished bit, so the bit on air is the MSB
   // and the word is back in place after a full frame.
   assign current_bit  = code_ff[TOTAL_BITS-1];
   assign bit_high_len = current_bit ? 9'd1 : 9'd2;

   // Next state of the sequencer for one accepted beat.
   always_comb begin
      phase_in          = phase_ff;
      unit_counter_in   = unit_counter_ff;
      pulse_counter_in  = pulse_counter_ff;
      bit_index_in      = bit_index_ff;
      repeat_counter_in = repeat_counter_ff;
      code_in           = code_ff;
      if (req_accept) begin
         if (req_mode) begin
            if (phase_ff == PHASE_IDLE) begin
               code_in           = {req_code_high, req_code_low, 1'b0};
               unit_counter_in   = 8'd0;
               pulse_counter_in  = 8'd0;
               bit_index_in      = '0;
               repeat_counter_in = 4'd0;
               phase_in          = PHASE_PRE;
            end
         end else begin
            case (phase_ff)
               PHASE_PRE: begin
                  if (unit_counter_ff == 8'd0) begin
                     unit_counter_in = 8'd1;
                  end else begin
                     unit_counter_in = 8'd0;
                     if (pulse_plus_one >= preamble_limit) begin
                        pulse_counter_in = 8'd0;
                        phase_in         = PHASE_START;
                     end else begin
                        pulse_counter_in = pulse_plus_one[7:0];
                     end
                  end
               end
               PHASE_START: begin
                  if (unit_wide >= start_limit) begin
                     unit_counter_in = 8'd0;
                     bit_index_in    = '0;
                     phase_in        = PHASE_BITS;
                  end else begin
                     unit_counter_in = unit_plus_one[7:0];
                  end
               end
               PHASE_BITS: begin
                  if (unit_wide >= BIT_LAST_UNIT) begin
                     unit_counter_in = 8'd0;
                     code_in         = {code_ff[TOTAL_BITS-2:0], code_ff[TOTAL_BITS-1]};
                     if (bit_index_plus_one >= (BIT_INDEX_WIDTH+1)'(TOTAL_BITS)) begin
                        bit_index_in = '0;
                        phase_in     = PHASE_GAP;
                     end else begin
                        bit_index_in = bit_index_plus_one[BIT_INDEX_WIDTH-1:0];
                     end
                  end else begin
                     unit_counter_in = unit_plus_one[7:0];
                  end
               end
               PHASE_GAP: begin
                  if (unit_plus_one >= gap_limit) begin
                     unit_counter_in = 8'd0;
                     if (repeat_plus_one >= repeat_limit) begin
                        repeat_counter_in = 4'd0;
                        phase_in          = PHASE_IDLE;
                     end else begin
                        repeat_counter_in = repeat_plus_one[3:0];
                        phase_in          = PHASE_PRE;
                     end
                  end else begin
                     unit_counter_in = unit_plus_one[7:0];
                  end
               end
               default: begin
                  phase_in = PHASE_IDLE;
               end
            endcase
         end
      end
   end

   // Result of one accepted beat, and the response register handshake.
   always_comb begin
      line_level_in = line_level_ff;
      busy_in       = busy_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         line_level_in = 1'b0;
         done_in       = 1'b0;
         if (req_mode) begin
            // A start always leaves a transmission in progress.
            busy_in = 1'b1;
         end else begin
            busy_in = (phase_ff != PHASE_IDLE);
            case (phase_ff)
               PHASE_PRE: begin
                  line_level_in = (unit_counter_ff == 8'd0);
               end
               PHASE_START: begin
                  line_level_in = (unit_wide < start_limit);
               end
               PHASE_BITS: begin
                  line_level_in = (unit_wide < bit_high_len);
               end
               PHASE_GAP: begin
                  done_in = (unit_plus_one >= gap_limit) && (repeat_plus_one >= repeat_limit);
               end
               default: begin
                  line_level_in = 1'b0;
               end
            endcase
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_pulses_ff  <= PREAMBLE_PULSES_RESET;
         repeat_count_ff     <= REPEAT_COUNT_RESET;
         start_high_units_ff <= START_HIGH_UNITS_RESET;
         gap_units_ff        <= GAP_UNITS_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PREAMBLE_PULSES:  preamble_pulses_ff  <= csr_wdata[7:0];
            CSR_REPEAT_COUNT:     repeat_count_ff     <= csr_wdata[3:0];
            CSR_START_HIGH_UNITS: start_high_units_ff <= csr_wdata[3:0];
            CSR_GAP_UNITS:        gap_units_ff        <= csr_wdata[7:0];
            default: begin
               preamble_pulses_ff <= preamble_pulses_ff;
            end
         endcase
      end
   end

   // Sequencer control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PHASE_IDLE;
         unit_counter_ff   <= 8'd0;
         pulse_counter_ff  <= 8'd0;
         bit_index_ff      <= '0;
         repeat_counter_ff <= 4'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         unit_counter_ff   <= unit_counter_in;
         pulse_counter_ff  <= pulse_counter_in;
         bit_index_ff      <= bit_index_in;
         repeat_counter_ff <= repeat_counter_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Code word and response payload.
   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      line_level_ff <= line_level_in;
      busy_ff       <= busy_in;
      done_ff       <= done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = line_level_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_done_res   = done_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the pulse-width remote code transmitter.
// Depends on rcpwt_pkg and remote_code_pulse_width_transmitter; a directed table runs first,
// then random phases; each beat is checked against its table entry or a local sequencer model.

module testbench;
   import rcpwt_pkg::*;

   localparam int MAX_WAIT      = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_PHASES = 2;
   localparam int PHASE_BEATS   = 150;
   localparam int DIRECTED_ROWS = 18;

   // One response beat, in port order.
   typedef struct packed {
      logic line_level;
      logic busy;
      logic done;
   } unit_result_type;

   typedef enum {ROW_BEAT, ROW_FLUSH, ROW_CSR} row_op_type;

   // One directed step: a request beat, a run to idle, or a register write.
   typedef struct {
      row_op_type                op;
      logic                      mode;
      logic [HIGH_BITS-1:0]      code_high;
      logic [LOW_BITS-2:0]       code_low;
      csr_index_type             reg_sel;
      logic [CSR_DATA_WIDTH-1:0] reg_value;
      bit                        known;
      unit_result_type           want;
   } stim_row_type;

   logic                       clock;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic                       req_mode      = 1'b0;
   logic [HIGH_BITS-1:0]       req_code_high = '0;
   logic [LOW_BITS-2:0]        req_code_low  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic                       rsp_line_level;
   logic                       rsp_busy_res;
   logic                       rsp_done_res;
   logic                       csr_we        = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata     = '0;

   // Local copy of the sequencer state and its registers.
   phase_type                  tx_phase      = PHASE_IDLE;
   logic [7:0]                 unit_cnt      = '0;
   logic [7:0]                 pulse_cnt     = '0;
   logic [BIT_INDEX_WIDTH-1:0] bit_pos       = '0;
   logic [3:0]                 frame_cnt     = '0;
   logic [TOTAL_BITS-1:0]      code_word     = '0;
   logic [7:0]                 cfg_preamble  = PREAMBLE_PULSES_RESET;
   logic [3:0]                 cfg_repeat    = REPEAT_COUNT_RESET;
   logic [3:0]                 cfg_start_len = START_HIGH_UNITS_RESET;
   logic [7:0]                 cfg_gap       = GAP_UNITS_RESET;

   unit_result_type expected_units[$];
   int              mismatch_count   = 0;
   int              cycle_count      = 0;
   bit              steady_flow      = 1'b0;
   bit              hold_off_request = 1'b0;

   remote_code_pulse_width_transmitter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_code_high  (req_code_high),
      .req_code_low   (req_code_low),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_level (rsp_line_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the sequencer model by one request beat and return the line state it produces.
   function automatic unit_result_type step_sequencer(input logic mode,
                                                      input logic [HIGH_BITS-1:0] hi,
                                                      input logic [LOW_BITS-2:0] lo);
      unit_result_type r;
      int              span;
      r = '0;
      if (mode) begin
         // A start is taken only while idle; no time unit passes.
         if (tx_phase == PHASE_IDLE) begin
            code_word = {hi, lo, 1'b0};
            unit_cnt  = '0;
            pulse_cnt = '0;
            bit_pos   = '0;
            frame_cnt = '0;
            tx_phase  = PHASE_PRE;
         end
         r.busy = (tx_phase != PHASE_IDLE);
         return r;
      end
      r.busy = (tx_phase != PHASE_IDLE);
      case (tx_phase)
         PHASE_PRE: begin
            r.line_level = (unit_cnt == 8'd0);
            if (unit_cnt == 8'd0) begin
               unit_cnt = 8'd1;
            end else begin
               unit_cnt = '0;
               span = (cfg_preamble == 8'd0) ? 1 : int'(cfg_preamble);
               if (int'(pulse_cnt) + 1 >= span) begin
                  pulse_cnt = '0;
                  tx_phase  = PHASE_START;
               end else begin
                  pulse_cnt = pulse_cnt + 8'd1;
               end
            end
         end
         PHASE_START: begin
            span = (cfg_start_len == 4'd0) ? 1 : int'(cfg_start_len);
            r.line_level = (int'(unit_cnt) < span);
            if (int'(unit_cnt) >= span) begin
               unit_cnt = '0;
               bit_pos  = '0;
               tx_phase = PHASE_BITS;
            end else begin
               unit_cnt = unit_cnt + 8'd1;
            end
         end
         PHASE_BITS: begin
            // A one is one unit high, a zero two; every symbol is three units long.
            span = code_word[TOTAL_BITS-1-bit_pos] ? 1 : 2;
            r.line_level = (int'(unit_cnt) < span);
            if (unit_cnt >= 8'd2) begin
               unit_cnt = '0;
               bit_pos  = bit_pos + 1'b1;
               if (int'(bit_pos) >= TOTAL_BITS) begin
                  bit_pos  = '0;
                  tx_phase = PHASE_GAP;
               end
            end else begin
               unit_cnt = unit_cnt + 8'd1;
            end
         end
         PHASE_GAP: begin
            span = (cfg_gap == 8'd0) ? 1 : int'(cfg_gap);
            if (int'(unit_cnt) + 1 >= span) begin
               unit_cnt  = '0;
               frame_cnt = frame_cnt + 4'd1;
               if (int'(frame_cnt) >= ((cfg_repeat == 4'd0) ? 1 : int'(cfg_repeat))) begin
                  frame_cnt = '0;
                  tx_phase  = PHASE_IDLE;
                  r.done    = 1'b1;
               end else begin
                  tx_phase = PHASE_PRE;
               end
            end else begin
               unit_cnt = unit_cnt + 8'd1;
            end
         end
         default: begin
            tx_phase = PHASE_IDLE;
         end
      endcase
      return r;
   endfunction

   // Offer one request beat, after a random gap unless the flow is steady, and record what it should produce.
   task automatic send_beat(input logic mode, input logic [HIGH_BITS-1:0] hi,
                            input logic [LOW_BITS-2:0] lo, input bit known,
                            input unit_result_type want);
      int              gap;
      unit_result_type predicted;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_code_high <= hi;
      req_code_low  <= lo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_sequencer(mode, hi, lo);
      expected_units.push_back(known ? want : predicted);
   endtask

   // Write one register once every response beat has come back.
   task automatic write_register(input csr_index_type sel,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (sel)
         CSR_PREAMBLE_PULSES:  cfg_preamble  = value[7:0];
         CSR_REPEAT_COUNT:     cfg_repeat    = value[3:0];
         CSR_START_HIGH_UNITS: cfg_start_len = value[3:0];
         CSR_GAP_UNITS:        cfg_gap       = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Keep ticking until the model says the transmission has ended.
   task automatic run_to_idle();
      while (tx_phase != PHASE_IDLE) begin
         send_beat(1'b0, HIGH_BITS'($urandom), (LOW_BITS-1)'($urandom), 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      stim_row_type directed_rows [DIRECTED_ROWS];
      int           beats;
      int           waited;
      logic         mode;

      // Expected beats are given as {line_level, busy, done}.
      directed_rows = '{
         // Reset settings: idle tick, start with all ones, start while busy, first units.
         '{ROW_BEAT,  1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b000},
         '{ROW_BEAT,  1'b1, 32'hFFFF_FFFF, 23'h7F_FFFF, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b010},
         '{ROW_BEAT,  1'b1, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b010},
         '{ROW_BEAT,  1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b110},
         '{ROW_BEAT,  1'b0, 32'hFFFF_FFFF, 23'h7F_FFFF, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b010},
         // Shorter frames set mid-transmission; the start length keeps its low four bits.
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h01, 1'b0, 3'b000},
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_REPEAT_COUNT, 8'h02, 1'b0, 3'b000},
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_START_HIGH_UNITS, 8'hFF, 1'b0, 3'b000},
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_GAP_UNITS, 8'h01, 1'b0, 3'b000},
         '{ROW_FLUSH, 1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b0, 3'b000},
         '{ROW_BEAT,  1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b000},
         // Zero in every register acts as one.
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b0, 3'b000},
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_REPEAT_COUNT, 8'h00, 1'b0, 3'b000},
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_START_HIGH_UNITS, 8'h00, 1'b0, 3'b000},
         '{ROW_CSR,   1'b0, 32'h0000_0000, 23'h00_0000, CSR_GAP_UNITS, 8'h00, 1'b0, 3'b000},
         '{ROW_BEAT,  1'b1, 32'hA5A5_A5A5, 23'h5A_5A5A, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b010},
         '{ROW_FLUSH, 1'b0, 32'h0000_0000, 23'h00_0000, CSR_PREAMBLE_PULSES, 8'h00, 1'b0, 3'b000},
         '{ROW_BEAT,  1'b0, 32'hFFFF_FFFF, 23'h7F_FFFF, CSR_PREAMBLE_PULSES, 8'h00, 1'b1, 3'b000}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         case (directed_rows[i].op)
            ROW_BEAT: begin
               send_beat(directed_rows[i].mode, directed_rows[i].code_high,
                         directed_rows[i].code_low, directed_rows[i].known,
                         directed_rows[i].want);
            end
            ROW_FLUSH: begin
               run_to_idle();
            end
            default: begin
               write_register(directed_rows[i].reg_sel, directed_rows[i].reg_value);
            end
         endcase
      end

      // Random phases, each with its own settings; mostly starts followed by ticks.
      // The first runs back to back, the second has the long receiver hold-off.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady_flow = (p == 0);
         write_register(CSR_PREAMBLE_PULSES, 8'($urandom_range(1, 6)));
         write_register(CSR_GAP_UNITS, 8'($urandom_range(1, 24)));
         write_register(CSR_REPEAT_COUNT, 8'd1);
         write_register(CSR_START_HIGH_UNITS, 8'($urandom_range(1, 15)));
         if (p == 1) begin
            hold_off_request = 1'b1;
         end
         beats = 0;
         while (beats < PHASE_BEATS) begin
            if (tx_phase == PHASE_IDLE) begin
               mode = ($urandom_range(0, 99) < 85);
            end else begin
               mode = ($urandom_range(0, 99) < 4);
            end
            // A start while busy is ignored and does not count.
            if (!(mode && tx_phase != PHASE_IDLE)) begin
               beats++;
            end
            send_beat(mode, HIGH_BITS'($urandom), (LOW_BITS-1)'($urandom), 1'b0, '0);
         end
         run_to_idle();
      end

      // Drain the response channel, then allow a few more cycles for stray beats.
      req_valid <= 1'b0;
      waited = 0;
      while (expected_units.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (expected_units.size() != 0) begin
         $error("%0d response beats never arrived", expected_units.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("remote_code_pulse_width_transmitter regression: pass");
      end else begin
         $display("remote_code_pulse_width_transmitter regression: fail");
      end
      $finish;
   end

   // Response side: random stalls, one long hold-off, and a field-by-field check.
   initial begin : response_sink
      int              stall;
      unit_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (expected_units.size() == 0) begin
            $error("response beat with no request pending: line_level %0b busy %0b done %0b",
                   rsp_line_level, rsp_busy_res, rsp_done_res);
            mismatch_count++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_line_level !== want.line_level) begin
               $error("line_level: expected %0b, got %0b", want.line_level, rsp_line_level);
               mismatch_count++;
            end
            if (rsp_busy_res !== want.busy) begin
               $error("busy_res: expected %0b, got %0b", want.busy, rsp_busy_res);
               mismatch_count++;
            end
            if (rsp_done_res !== want.done) begin
               $error("done_res: expected %0b, got %0b", want.done, rsp_done_res);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("remote_code_pulse_width_transmitter regression: fail");
         $finish;
      end
   end

endmodule
